FILE: src/msq_pkg.sv
package msq_pkg;

  localparam int SEG_SLOTS_DEF = 16;
  localparam int AXIS_COUNT    = 3;

  localparam int REQ_W   = 3;
  localparam int ID_W    = 16;
  localparam int TICK_W  = 24;
  localparam int DUR_W   = 26;
  localparam int POS_W   = 32;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 4;

  localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_START  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PAUSE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RESUME = 3'd4;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_ESTOP  = 3'd6;

  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ESTOP = 2'd3;

  typedef logic signed [POS_W-1:0] pos_t;

  // Classified command handed from the front end to the sequencer.
  typedef struct packed {
    logic [REQ_W-1:0]             req;
    logic [ID_W-1:0]              seg_id;
    logic [DUR_W-1:0]             dur;
    logic [AXIS_COUNT-1:0][POS_W-1:0] tgt;
  } cmd_t;

  // One segment as stored in the segment queue.
  typedef struct packed {
    logic [ID_W-1:0]              id;
    logic [DUR_W-1:0]             dur;
    logic [AXIS_COUNT-1:0][POS_W-1:0] tgt;
  } seg_t;

endpackage

FILE: src/msq_front.sv
module msq_front
  import msq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        req_type,
  input  logic [ID_W-1:0]         seg_id,
  input  logic [TICK_W-1:0]       accel_len,
  input  logic [TICK_W-1:0]       cruise_len,
  input  logic [TICK_W-1:0]       decel_len,
  input  logic signed [POS_W-1:0] target_x,
  input  logic signed [POS_W-1:0] target_y,
  input  logic signed [POS_W-1:0] target_z,
  output logic                    cmd_valid,
  input  logic                    cmd_ready,
  output cmd_t                    cmd
);

  logic [DUR_W-1:0] dur_sum;
  logic             take;

  assign in_ready = !cmd_valid || cmd_ready;
  assign take     = in_valid && in_ready;

  // total segment length; three 24-bit phases fit in 26 bits
  assign dur_sum = {2'b00, accel_len} + {2'b00, cruise_len} + {2'b00, decel_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (take) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd.req    <= req_type;
      cmd.seg_id <= seg_id;
      cmd.dur    <= dur_sum;
      cmd.tgt[0] <= target_x;
      cmd.tgt[1] <= target_y;
      cmd.tgt[2] <= target_z;
    end
  end

endmodule

FILE: src/msq_cmd_fifo.sv
module msq_cmd_fifo
  import msq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t       slots [2];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_idx <= !wr_idx;
      end
      if (pop) begin
        rd_idx <= !rd_idx;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= wr_data;
    end
  end

endmodule

FILE: src/msq_back.sv
module msq_back
  import msq_pkg::*;
#(
  parameter int SEG_SLOTS = SEG_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  cmd_t                    cmd_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    accepted,
  output logic [MODE_W-1:0]       run_mode,
  output logic                    estop_alarm,
  output logic [COUNT_W-1:0]      queue_count,
  output logic                    active_flag,
  output logic [ID_W-1:0]         current_id,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z
);

  localparam int PW = (SEG_SLOTS > 1) ? $clog2(SEG_SLOTS) : 1;
  localparam logic [PW-1:0] LAST = PW'(SEG_SLOTS - 1);

  typedef enum logic [3:0] {
    S_WAIT   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SETTLE = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + PW'(1);
  endfunction

  state_t                         state;
  cmd_t                           cmd;
  seg_t                           mem [SEG_SLOTS];
  seg_t                           head;
  logic [PW-1:0]                  wr_ptr;
  logic [PW-1:0]                  rd_ptr;
  logic [MODE_W-1:0]              mode;
  logic                           alarm_latch;
  logic                           seg_active;
  logic [DUR_W-1:0]               tick_count;
  logic [DUR_W-1:0]               act_dur;
  logic [AXIS_COUNT-1:0][POS_W-1:0] act_tgt;
  logic [ID_W-1:0]                act_id;
  logic [AXIS_COUNT-1:0][POS_W-1:0] pos;
  logic                           acc;

  logic                           slot_free;
  logic                           take;
  logic                           full;
  logic                           do_push;
  logic [DUR_W-1:0]               tick_inc;
  logic [PW:0]                    diff;
  logic [PW+COUNT_W:0]            diff_ext;

  assign slot_free = !out_valid || out_ready;
  assign cmd_ready = (state == S_WAIT) || (state == S_RESP && slot_free);
  assign take      = cmd_valid && cmd_ready;
  assign full      = (ptr_inc(wr_ptr) == rd_ptr);
  assign do_push   = (state == S_EXEC) && (cmd.req == REQ_PUSH) && !full;
  assign tick_inc  = tick_count + DUR_W'(1);

  assign diff = (wr_ptr >= rd_ptr) ? ({1'b0, wr_ptr} - {1'b0, rd_ptr})
                                   : ({1'b0, wr_ptr} + (PW+1)'(SEG_SLOTS) - {1'b0, rd_ptr});
  assign diff_ext = {{COUNT_W{1'b0}}, diff};

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_in;
    end
  end

  // segment store: one write port, registered read of the queue head
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= '{id: cmd.seg_id, dur: cmd.dur, tgt: cmd.tgt};
    end
    head <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_WAIT;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      mode        <= MODE_IDLE;
      alarm_latch <= 1'b0;
      seg_active  <= 1'b0;
      tick_count  <= '0;
      act_dur     <= '0;
      act_tgt     <= '0;
      act_id      <= '0;
      pos         <= '0;
      acc         <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_RESP && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_WAIT: begin
          if (take) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          acc   <= !(cmd.req == REQ_PUSH && full);
          state <= S_SETTLE;
          case (cmd.req)
            REQ_PUSH: begin
              if (!full) begin
                wr_ptr <= ptr_inc(wr_ptr);
              end
            end
            REQ_TICK: begin
              if (mode == MODE_RUN && seg_active) begin
                tick_count <= tick_inc;
                if (tick_inc >= act_dur) begin
                  pos        <= act_tgt;
                  seg_active <= 1'b0;
                end
              end
            end
            REQ_START: begin
              if (mode == MODE_IDLE || mode == MODE_PAUSE) begin
                mode <= MODE_RUN;
              end
            end
            REQ_PAUSE: begin
              if (mode == MODE_RUN) begin
                mode <= MODE_PAUSE;
              end
            end
            REQ_RESUME: begin
              if (mode == MODE_PAUSE) begin
                mode <= MODE_RUN;
              end
            end
            REQ_STOP: begin
              mode       <= MODE_IDLE;
              wr_ptr     <= '0;
              rd_ptr     <= '0;
              seg_active <= 1'b0;
            end
            REQ_ESTOP: begin
              mode        <= MODE_ESTOP;
              alarm_latch <= 1'b1;
              wr_ptr      <= '0;
              rd_ptr      <= '0;
              seg_active  <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        S_SETTLE: begin
          // head was read at rd_ptr during EXEC; a pop never follows a push
          if (mode == MODE_RUN && !seg_active) begin
            if (wr_ptr != rd_ptr) begin
              act_id     <= head.id;
              act_dur    <= head.dur;
              act_tgt    <= head.tgt;
              rd_ptr     <= ptr_inc(rd_ptr);
              seg_active <= 1'b1;
              tick_count <= '0;
            end else begin
              mode <= MODE_IDLE;
            end
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            state <= take ? S_EXEC : S_WAIT;
          end
        end
        default: begin
          state <= S_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && slot_free) begin
      accepted    <= acc;
      run_mode    <= mode;
      estop_alarm <= alarm_latch;
      queue_count <= diff_ext[COUNT_W-1:0];
      active_flag <= seg_active;
      current_id  <= act_id;
      pos_x       <= pos[0];
      pos_y       <= pos[1];
      pos_z       <= pos[2];
    end
  end

  a_run_has_segment: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && mode == MODE_RUN) |-> seg_active)
    else $error("running without a segment at response time");

  a_stop_flushes: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && (cmd.req == REQ_STOP || cmd.req == REQ_ESTOP))
      |=> (wr_ptr == rd_ptr && !seg_active))
    else $error("stop did not flush the queue");

  a_alarm_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> !$fell(alarm_latch))
    else $error("alarm cleared without reset");

  a_resp_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> !(state == S_EXEC && $past(state) == S_RESP))
    else $error("new transaction started while result stalled");

endmodule

FILE: src/motion_segment_queue_sequencer.sv
// Path: front-end input register, two-entry command FIFO, then the back-end sequencer,
//   which works one command at a time (execute, queue-head settle, result load) and
//   takes no new command until its result is loaded into the free output register.
// Reset: synchronous, active high; empties both queues, run mode idle, alarm
//   clear, positions and current segment zero. No clearing pass is needed.
module motion_segment_queue_sequencer
  import msq_pkg::*;
#(
  parameter int SEG_SLOTS = SEG_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        req_type,
  input  logic [ID_W-1:0]         seg_id,
  input  logic [TICK_W-1:0]       accel_len,
  input  logic [TICK_W-1:0]       cruise_len,
  input  logic [TICK_W-1:0]       decel_len,
  input  logic signed [POS_W-1:0] target_x,
  input  logic signed [POS_W-1:0] target_y,
  input  logic signed [POS_W-1:0] target_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    accepted,
  output logic [MODE_W-1:0]       run_mode,
  output logic                    estop_alarm,
  output logic [COUNT_W-1:0]      queue_count,
  output logic                    active_flag,
  output logic [ID_W-1:0]         current_id,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z
);

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  msq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .seg_id     (seg_id),
    .accel_len  (accel_len),
    .cruise_len (cruise_len),
    .decel_len  (decel_len),
    .target_x   (target_x),
    .target_y   (target_y),
    .target_z   (target_z),
    .cmd_valid  (front_valid),
    .cmd_ready  (front_ready),
    .cmd        (front_cmd)
  );

  msq_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  msq_back #(
    .SEG_SLOTS (SEG_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd_in      (q_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .accepted    (accepted),
    .run_mode    (run_mode),
    .estop_alarm (estop_alarm),
    .queue_count (queue_count),
    .active_flag (active_flag),
    .current_id  (current_id),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z)
  );

endmodule

FILE: dv/msq_tb_pkg.sv
`timescale 1ns / 1ps

package msq_tb_pkg;
  import msq_pkg::*;

  // 7 is left unassigned by the block; it must answer like a no-op
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic                 acc;
    logic [MODE_W-1:0]    mode;
    logic                 alarm;
    logic [COUNT_W-1:0]   count;
    logic                 busy;
    logic [ID_W-1:0]      id;
    pos_t                 px;
    pos_t                 py;
    pos_t                 pz;
  } status_t;

  class motion_scoreboard;
    // segment queue copy
    logic [ID_W-1:0]  q_id  [SEG_SLOTS_DEF];
    logic [DUR_W-1:0] q_len [SEG_SLOTS_DEF];
    pos_t             q_tgt [SEG_SLOTS_DEF][AXIS_COUNT];
    int               wr;
    int               rd;
    // sequencer state copy
    logic [MODE_W-1:0] mode;
    bit                alarm;
    bit                busy;
    logic [DUR_W-1:0]  ticks;
    logic [DUR_W-1:0]  len;
    pos_t              tgt [AXIS_COUNT];
    logic [ID_W-1:0]   cur_id;
    pos_t              pos [AXIS_COUNT];
    status_t           status_q[$];
    int                errors;

    function new();
      wr     = 0;
      rd     = 0;
      mode   = MODE_IDLE;
      alarm  = 0;
      busy   = 0;
      ticks  = '0;
      len    = '0;
      cur_id = '0;
      errors = 0;
      for (int a = 0; a < AXIS_COUNT; a++) begin
        tgt[a] = '0;
        pos[a] = '0;
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void flush();
      wr   = 0;
      rd   = 0;
      busy = 0;
    endfunction

    // Advance the state copy by one accepted command and queue the status it yields.
    function void note_cmd(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                           logic [TICK_W-1:0] ta, logic [TICK_W-1:0] tc,
                           logic [TICK_W-1:0] td, pos_t tx, pos_t ty, pos_t tz);
      status_t s;
      int      nxt;
      s.acc = 1'b1;
      case (req)
        REQ_PUSH: begin
          nxt = (wr + 1) % SEG_SLOTS_DEF;
          if (nxt == rd) begin
            s.acc = 1'b0;
          end else begin
            q_id[wr]     = id;
            q_len[wr]    = DUR_W'(ta) + DUR_W'(tc) + DUR_W'(td);
            q_tgt[wr][0] = tx;
            q_tgt[wr][1] = ty;
            q_tgt[wr][2] = tz;
            wr = nxt;
          end
        end
        REQ_TICK: begin
          if (mode == MODE_RUN && busy) begin
            ticks = ticks + DUR_W'(1);
            if (ticks >= len) begin
              for (int a = 0; a < AXIS_COUNT; a++) pos[a] = tgt[a];
              busy = 0;
            end
          end
        end
        REQ_START: begin
          if (mode == MODE_IDLE || mode == MODE_PAUSE) mode = MODE_RUN;
        end
        REQ_PAUSE: begin
          if (mode == MODE_RUN) mode = MODE_PAUSE;
        end
        REQ_RESUME: begin
          if (mode == MODE_PAUSE) mode = MODE_RUN;
        end
        REQ_STOP: begin
          mode = MODE_IDLE;
          flush();
        end
        REQ_ESTOP: begin
          mode  = MODE_ESTOP;
          alarm = 1;
          flush();
        end
        default: ;
      endcase

      // pop next segment, or fall back to idle on an empty queue
      if (mode == MODE_RUN && !busy) begin
        if (wr != rd) begin
          cur_id = q_id[rd];
          len    = q_len[rd];
          for (int a = 0; a < AXIS_COUNT; a++) tgt[a] = q_tgt[rd][a];
          rd    = (rd + 1) % SEG_SLOTS_DEF;
          busy  = 1;
          ticks = '0;
        end else begin
          mode = MODE_IDLE;
        end
      end

      s.mode  = mode;
      s.alarm = alarm;
      s.count = COUNT_W'((wr + SEG_SLOTS_DEF - rd) % SEG_SLOTS_DEF);
      s.busy  = busy;
      s.id    = cur_id;
      s.px    = pos[0];
      s.py    = pos[1];
      s.pz    = pos[2];
      status_q.push_back(s);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (status_q.size() == 0) begin
        $error("status transaction with nothing outstanding");
        errors++;
        return;
      end
      want = status_q.pop_front();
      check_field("accepted",    32'(want.acc),   32'(got.acc));
      check_field("run_mode",    32'(want.mode),  32'(got.mode));
      check_field("estop_alarm", 32'(want.alarm), 32'(got.alarm));
      check_field("queue_count", 32'(want.count), 32'(got.count));
      check_field("active_flag", 32'(want.busy),  32'(got.busy));
      check_field("current_id",  32'(want.id),    32'(got.id));
      check_field("pos_x",       want.px,         got.px);
      check_field("pos_y",       want.py,         got.py);
      check_field("pos_z",       want.pz,         got.pz);
    endfunction
  endclass

endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import msq_pkg::*;
  import msq_tb_pkg::*;

  localparam int NUM_ITEMS = 1650;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [REQ_W-1:0]    req_type;
  logic [ID_W-1:0]     seg_id;
  logic [TICK_W-1:0]   accel_len;
  logic [TICK_W-1:0]   cruise_len;
  logic [TICK_W-1:0]   decel_len;
  pos_t                target_x;
  pos_t                target_y;
  pos_t                target_z;
  logic                out_valid;
  logic                out_ready;
  logic                accepted;
  logic [MODE_W-1:0]   run_mode;
  logic                estop_alarm;
  logic [COUNT_W-1:0]  queue_count;
  logic                active_flag;
  logic [ID_W-1:0]     current_id;
  pos_t                pos_x;
  pos_t                pos_y;
  pos_t                pos_z;

  motion_scoreboard sb;
  int  n_sent;
  bit  quiet;
  bit  long_hold;

  motion_segment_queue_sequencer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .seg_id       (seg_id),
    .accel_len    (accel_len),
    .cruise_len   (cruise_len),
    .decel_len    (decel_len),
    .target_x     (target_x),
    .target_y     (target_y),
    .target_z     (target_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .run_mode     (run_mode),
    .estop_alarm  (estop_alarm),
    .queue_count  (queue_count),
    .active_flag  (active_flag),
    .current_id   (current_id),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  task automatic send_cmd(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                          input logic [TICK_W-1:0] ta, input logic [TICK_W-1:0] tc,
                          input logic [TICK_W-1:0] td, input pos_t tx, input pos_t ty,
                          input pos_t tz);
    if (!quiet && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    seg_id       <= id;
    accel_len    <= ta;
    cruise_len   <= tc;
    decel_len    <= td;
    target_x     <= tx;
    target_y     <= ty;
    target_z     <= tz;
    do @(posedge clk); while (!in_ready);
    sb.note_cmd(req, id, ta, tc, td, tx, ty, tz);
    n_sent++;
  endtask

  // non-push command; payload is still randomized since the block must ignore it
  task automatic send_op(input logic [REQ_W-1:0] req);
    send_cmd(req, ID_W'($urandom), TICK_W'($urandom), TICK_W'($urandom),
             TICK_W'($urandom), $urandom, $urandom, $urandom);
  endtask

  task automatic send_push(input bit long_seg);
    logic [TICK_W-1:0] ta, tc, td;
    ta = long_seg ? TICK_W'($urandom_range(0, 24'hFFFFFF)) : TICK_W'($urandom_range(0, 3));
    tc = long_seg ? TICK_W'($urandom_range(0, 24'hFFFFFF)) : TICK_W'($urandom_range(0, 3));
    td = long_seg ? TICK_W'($urandom_range(0, 24'hFFFFFF)) : TICK_W'($urandom_range(0, 3));
    send_cmd(REQ_PUSH, ID_W'($urandom), ta, tc, td, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // push a batch, start it and tick it through with the odd pause/resume mixed in
  task automatic run_program();
    int k;
    int r;
    if (sb.mode == MODE_ESTOP || (sb.busy && sb.len > 64)) send_op(REQ_STOP);
    k = $urandom_range(1, 6);
    repeat (k) send_push($urandom_range(0, 11) == 0);
    send_op(REQ_START);
    repeat (k * 7 + 2) begin
      r = $urandom_range(0, 99);
      if (r < 4)       send_op(REQ_PAUSE);
      else if (r < 8)  send_op(REQ_RESUME);
      else if (r < 10) send_op(REQ_START);
      else             send_op(REQ_TICK);
    end
    if ($urandom_range(0, 9) == 0) send_op(REQ_STOP);
  endtask

  // result side: random backpressure plus one long hold-off on request
  initial begin
    int stall_left;
    status_t got;
    stall_left = 0;
    out_ready  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_valid && out_ready) begin
        got.acc   = accepted;
        got.mode  = run_mode;
        got.alarm = estop_alarm;
        got.count = queue_count;
        got.busy  = active_flag;
        got.id    = current_id;
        got.px    = pos_x;
        got.py    = pos_y;
        got.pz    = pos_z;
        sb.check_status(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (long_hold) begin
        long_hold  = 1'b0;
        stall_left = 400;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    int  roll;
    bit  held;
    bit  drained;
    sb           = new();
    n_sent       = 0;
    quiet        = 1'b0;
    long_hold    = 1'b0;
    held         = 1'b0;
    drained      = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_TICK;
    seg_id       = '0;
    accel_len    = '0;
    cruise_len   = '0;
    decel_len    = '0;
    target_x     = '0;
    target_y     = '0;
    target_z     = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ignored commands while idle, empty start
    send_op(REQ_TICK);
    send_op(REQ_PAUSE);
    send_op(REQ_RESUME);
    send_op(REQ_UNUSED);
    send_op(REQ_START);
    // fill the queue: two zero-length extremes, one maximal length, then filler
    send_cmd(REQ_PUSH, '0, '0, '0, '0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_cmd(REQ_PUSH, 16'hFFFF, '0, '0, '0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_cmd(REQ_PUSH, ID_W'($urandom), 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, $urandom,
             $urandom, $urandom);
    repeat (12) send_push(1'b0);
    send_push(1'b0);                    // full queue, must be rejected
    send_op(REQ_START);
    send_op(REQ_TICK);                  // zero-length segment completes at once
    send_op(REQ_TICK);
    send_op(REQ_PAUSE);
    send_op(REQ_TICK);                  // no effect while paused
    send_op(REQ_START);
    send_op(REQ_PAUSE);
    send_op(REQ_RESUME);
    send_op(REQ_STOP);
    send_op(REQ_ESTOP);
    send_push(1'b0);                    // stored even in estop
    send_op(REQ_START);
    send_op(REQ_STOP);

    while (n_sent < NUM_ITEMS) begin
      quiet = ((n_sent / 120) % 5) == 4;
      if (!held && n_sent > 500) begin
        long_hold = 1'b1;
        held      = 1'b1;
      end
      if (!drained && n_sent > 1000) begin
        wait_drain();
        drained = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        run_program();
      end else if (roll < 80) begin
        repeat (17) send_push(1'b0);
      end else begin
        repeat ($urandom_range(3, 8)) begin
          send_cmd(REQ_W'($urandom_range(0, 7)), ID_W'($urandom), TICK_W'($urandom),
                   TICK_W'($urandom), TICK_W'($urandom), $urandom, $urandom, $urandom);
        end
      end
    end

    wait_drain();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d status transactions never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: motion_segment_queue_sequencer.f
src/msq_pkg.sv
src/msq_front.sv
src/msq_cmd_fifo.sv
src/msq_back.sv
src/motion_segment_queue_sequencer.sv
dv/msq_tb_pkg.sv
dv/tb_top.sv
